### rtl/core/rmzyx_pkg.sv
// ----------------------------------------------------------------------------
// rmzyx_pkg
// Shared constants for the ZYX Euler angle extractor: CORDIC arctangent
// table, angle and threshold widths, register map.
// ----------------------------------------------------------------------------
package rmzyx_pkg;

	// angle and register widths
	localparam int ANG_W        = 16;
	localparam int THR_W        = 15;
	localparam int ACC_W        = 32;
	localparam int CORDIC_ITERS = 30;

	// register map, index of the register in the address space
	localparam logic REG_THRESH = 1'b0;
	localparam logic [THR_W-1:0] THR_RESET = 15'd1;

	// accumulator constants, 2^31 stands for pi
	localparam logic [ACC_W-1:0] Z_PI    = 32'h8000_0000;
	localparam logic [ACC_W-1:0] Z_ROUND = 32'h0000_8000;
	localparam logic [ANG_W-1:0] ANG_PI  = 16'h8000;

	// atan(2^-i) with 2^31 = pi
	localparam logic [ACC_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

endpackage

### rtl/core/rmzyx_cordic.sv
// ----------------------------------------------------------------------------
// rmzyx_cordic
// Pipelined vectoring CORDIC atan2, one stage per iteration, 16-bit binary
// angle out. Registered stages in order: quadrant stage, 30 iterations, rounding.
// ----------------------------------------------------------------------------
module rmzyx_cordic
	import rmzyx_pkg::*;
#(
	parameter int IW = 17
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [IW-1:0]    x,
	input  logic signed [IW-1:0]    y,
	output logic        [ANG_W-1:0] angle
);

	localparam int XW = IW + 2;

	logic signed [XW-1:0] xe;
	logic signed [XW-1:0] ye;
	logic signed [XW-1:0] xs [0:CORDIC_ITERS];
	logic signed [XW-1:0] ys [0:CORDIC_ITERS];
	logic [ACC_W-1:0]     zs [0:CORDIC_ITERS];
	logic                 sp [0:CORDIC_ITERS];
	logic [ANG_W-1:0]     spv [0:CORDIC_ITERS];
	logic [ACC_W-1:0]     zr;

	assign xe = XW'(x);
	assign ye = XW'(y);

	// quadrant fold and zero-y special case
	always_ff @(posedge clk) begin
		if (en) begin
			sp[0]  <= (ye == '0);
			spv[0] <= xe[XW-1] ? ANG_PI : '0;
			if (xe[XW-1]) begin
				xs[0] <= -xe;
				ys[0] <= -ye;
				zs[0] <= Z_PI;
			end else begin
				xs[0] <= xe;
				ys[0] <= ye;
				zs[0] <= '0;
			end
		end
	end

	// one vectoring iteration per stage
	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		logic pos;
		assign pos = !ys[i][XW-1] && (ys[i] != '0);
		always_ff @(posedge clk) begin
			if (en) begin
				sp[i+1]  <= sp[i];
				spv[i+1] <= spv[i];
				if (pos) begin
					xs[i+1] <= xs[i] + (ys[i] >>> i);
					ys[i+1] <= ys[i] - (xs[i] >>> i);
					zs[i+1] <= zs[i] + ATAN_TAB[i];
				end else begin
					xs[i+1] <= xs[i] - (ys[i] >>> i);
					ys[i+1] <= ys[i] + (xs[i] >>> i);
					zs[i+1] <= zs[i] - ATAN_TAB[i];
				end
			end
		end
	end

	// round to 16-bit binary angle
	assign zr = zs[CORDIC_ITERS] + Z_ROUND;

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= sp[CORDIC_ITERS] ? spv[CORDIC_ITERS] : zr[ACC_W-1 -: ANG_W];
		end
	end

endmodule

### rtl/core/rotation_matrix_to_euler_zyx.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_zyx
// ZYX Euler angles (yaw, pitch, roll) from a fixed-point rotation matrix.
// ----------------------------------------------------------------------------
// One matrix transfer is taken every cycle unless the output is stalled, and
// each produces one angle transfer after three front stages (input, squares,
// sum), one restoring square-root stage per result bit, then three parallel
// 32-stage CORDIC atan2 pipelines. The whole pipeline advances together and
// holds when the output is stalled.
// c = floor(sqrt(r00^2 + r10^2)); c below singular_threshold (register 0)
// selects the gimbal-lock branch: yaw = 0, roll = atan2(-r12, r11).
module rotation_matrix_to_euler_zyx
	import rmzyx_pkg::*;
#(
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// matrix channel
	input  logic                         mat_valid,
	output logic                         mat_ready,
	input  logic signed [DATA_WIDTH-1:0] r00,
	input  logic signed [DATA_WIDTH-1:0] r10,
	input  logic signed [DATA_WIDTH-1:0] r20,
	input  logic signed [DATA_WIDTH-1:0] r21,
	input  logic signed [DATA_WIDTH-1:0] r22,
	input  logic signed [DATA_WIDTH-1:0] r11,
	input  logic signed [DATA_WIDTH-1:0] r12,
	// angle channel
	output logic                         ang_valid,
	input  logic                         ang_ready,
	output logic signed [ANG_W-1:0]      yaw,
	output logic signed [ANG_W-1:0]      pitch,
	output logic signed [ANG_W-1:0]      roll,
	output logic                         singular,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int DW  = DATA_WIDTH;
	localparam int NW  = 2 * DW;
	localparam int IW  = DW + 1;
	localparam int CL  = CORDIC_ITERS + 2;
	localparam int LAT = DW + 3 + CL;

	typedef struct packed {
		logic signed [DW-1:0] r00;
		logic signed [DW-1:0] r10;
		logic signed [DW-1:0] r20;
		logic signed [DW-1:0] r21;
		logic signed [DW-1:0] r22;
		logic signed [DW-1:0] r11;
		logic signed [DW-1:0] r12;
	} mat_t;

	logic [THR_W-1:0]     thr_q;
	logic                 en;
	logic [LAT-1:0]       vld_q;
	mat_t                 mat_s [0:DW+2];
	logic signed [NW-1:0] sq0_s2;
	logic signed [NW-1:0] sq1_s2;
	logic [NW-1:0]        sqn_s [0:DW];
	logic [NW-1:0]        sqr_s [0:DW];
	logic                 sing_s [0:CL-1];
	logic [DW-1:0]        c;
	logic                 sing;
	logic signed [IW-1:0] yaw_x, yaw_y, pit_x, pit_y, rol_x, rol_y;
	logic [ANG_W-1:0]     yaw_a, pit_a, rol_a;
	logic                 wr;

	// register port
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && (paddr[2] == REG_THRESH);
	assign prdata = (paddr[2] == REG_THRESH) ? 32'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (wr) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// pipeline advance and valid bits
	assign en        = ang_ready || !vld_q[LAT-1];
	assign mat_ready = en;
	assign ang_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], mat_valid};
		end
	end

	// input, squares, sum
	always_ff @(posedge clk) begin
		if (en) begin
			mat_s[0] <= '{r00, r10, r20, r21, r22, r11, r12};
			mat_s[1] <= mat_s[0];
			sq0_s2   <= mat_s[0].r00 * mat_s[0].r00;
			sq1_s2   <= mat_s[0].r10 * mat_s[0].r10;
			mat_s[2] <= mat_s[1];
			sqn_s[0] <= $unsigned(sq0_s2) + $unsigned(sq1_s2);
			sqr_s[0] <= '0;
		end
	end

	// restoring square root, one result bit per stage
	for (genvar j = 0; j < DW; j++) begin : g_sqrt
		localparam int K = DW - 1 - j;
		logic [NW-1:0] b;
		logic [NW-1:0] t;
		assign b = NW'(1) << (2 * K);
		assign t = sqr_s[j] + b;
		always_ff @(posedge clk) begin
			if (en) begin
				mat_s[j+3] <= mat_s[j+2];
				if (sqn_s[j] >= t) begin
					sqn_s[j+1] <= sqn_s[j] - t;
					sqr_s[j+1] <= (sqr_s[j] >> 1) + b;
				end else begin
					sqn_s[j+1] <= sqn_s[j];
					sqr_s[j+1] <= sqr_s[j] >> 1;
				end
			end
		end
	end

	// branch select and CORDIC operands
	assign c    = sqr_s[DW][DW-1:0];
	assign sing = 32'(c) < 32'(thr_q);

	always_comb begin
		pit_x = IW'({1'b0, c});
		pit_y = -IW'(mat_s[DW+2].r20);
		if (sing) begin
			yaw_x = '0;
			yaw_y = '0;
			rol_x = IW'(mat_s[DW+2].r11);
			rol_y = -IW'(mat_s[DW+2].r12);
		end else begin
			yaw_x = IW'(mat_s[DW+2].r00);
			yaw_y = IW'(mat_s[DW+2].r10);
			rol_x = IW'(mat_s[DW+2].r22);
			rol_y = IW'(mat_s[DW+2].r21);
		end
	end

	rmzyx_cordic #(.IW(IW)) u_yaw (
		.clk(clk), .en(en), .x(yaw_x), .y(yaw_y), .angle(yaw_a)
	);

	rmzyx_cordic #(.IW(IW)) u_pitch (
		.clk(clk), .en(en), .x(pit_x), .y(pit_y), .angle(pit_a)
	);

	rmzyx_cordic #(.IW(IW)) u_roll (
		.clk(clk), .en(en), .x(rol_x), .y(rol_y), .angle(rol_a)
	);

	// singular flag follows the CORDIC latency
	always_ff @(posedge clk) begin
		if (en) begin
			sing_s[0] <= sing;
			for (int k = 1; k < CL; k++) begin
				sing_s[k] <= sing_s[k-1];
			end
		end
	end

	assign yaw      = $signed(yaw_a);
	assign pitch    = $signed(pit_a);
	assign roll     = $signed(rol_a);
	assign singular = sing_s[CL-1];

	// checks
	a_sing_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		ang_valid && singular |-> yaw == '0)
		else $error("yaw not zero on singular result");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!ang_valid |-> mat_ready)
		else $error("pipeline held without a stalled result");

	a_thr_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr |=> thr_q == $past(pwdata[THR_W-1:0]))
		else $error("threshold write lost");

endmodule
